>>> rtl/relative_l2_change_norm_assert.svh
// Assertion macros for the relative L2 change norm block.
// Used by the top level only; needs a clock and an active-low reset.
`ifndef RELATIVE_L2_CHANGE_NORM_ASSERT_SVH
`define RELATIVE_L2_CHANGE_NORM_ASSERT_SVH

// Same-cycle implication check
`define RLCN_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("rlcn: same-cycle check failed");

// Next-cycle implication check
`define RLCN_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("rlcn: next-cycle check failed");

`endif

>>> rtl/rlcn_pkg.sv
// Package for the relative L2 change norm block: widths, register codes,
// sequencer states and the request/status structs of the shift-subtract unit.
`default_nettype none

package rlcn_pkg;

  // Configuration port
  localparam int ADDR_W = 4;
  localparam logic [1:0] REG_VOLUME  = 2'd0;
  localparam logic [1:0] REG_EPSILON = 2'd1;
  localparam logic [1:0] REG_SPIN    = 2'd2;

  // Datapath widths
  localparam int ACC_W  = 64;
  localparam int RAD_W  = 72;  // radicand: (sum * volume) >> 24
  localparam int ROOT_W = 36;  // square root of the radicand
  localparam int REM_W  = 40;  // partial remainder
  localparam int RES_W  = 60;  // quotient of (root << 24) / root
  localparam int CNT_W  = 6;

  localparam logic [CNT_W-1:0] ROOT_LAST = 6'd35;
  localparam logic [CNT_W-1:0] QUO_LAST  = 6'd59;

  typedef enum logic {
    OP_SQRT,
    OP_DIV
  } rlcn_op_e;

  typedef struct packed {
    logic     start;
    rlcn_op_e op;
  } rlcn_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } rlcn_sts_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAG,
    ST_MUL,
    ST_ACC,
    ST_NMUL_LO,
    ST_NMUL_HI,
    ST_NSUM,
    ST_ROOT,
    ST_CHECK,
    ST_DIV,
    ST_CHAN,
    ST_DONE
  } rlcn_state_e;

endpackage

`default_nettype wire

>>> rtl/rlcn_shift_sub.sv
// Shared shift-subtract unit: bit-pair square root and restoring division,
// one result bit per cycle. Depends on rlcn_pkg.
`default_nettype none

module rlcn_shift_sub import rlcn_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rlcn_req_t          req_i,
  input  logic [RAD_W-1:0]   rad_i,
  input  logic [ROOT_W-1:0]  divisor_i,
  output rlcn_sts_t          sts_o,
  output logic [RES_W-1:0]   result_o
);

  logic             busy_q, done_q;
  rlcn_op_e         op_q;
  logic [CNT_W-1:0] cnt_q;
  logic [RAD_W-1:0] rad_q, rad_sh;
  logic [REM_W-1:0] rem_q, rem_sh, trial, rem_nx;
  logic [RES_W-1:0] res_q;
  logic [ROOT_W-1:0] div_q;
  logic             ge;

  // Form the shifted remainder and the trial subtrahend for this step
  always_comb begin
    case (op_q)
      OP_SQRT: begin
        rem_sh = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
        trial  = {{(REM_W-ROOT_W-2){1'b0}}, res_q[ROOT_W-1:0], 2'b01};
        rad_sh = {rad_q[RAD_W-3:0], 2'b00};
      end
      OP_DIV: begin
        rem_sh = {rem_q[REM_W-2:0], rad_q[RAD_W-1]};
        trial  = {{(REM_W-ROOT_W){1'b0}}, div_q};
        rad_sh = {rad_q[RAD_W-2:0], 1'b0};
      end
      default: begin
        rem_sh = rem_q;
        trial  = '0;
        rad_sh = rad_q;
      end
    endcase
    ge     = (rem_sh >= trial);
    rem_nx = ge ? (rem_sh - trial) : rem_sh;
  end

  // Sequence control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= OP_SQRT;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        op_q   <= req_i.op;
        cnt_q  <= (req_i.op == OP_SQRT) ? ROOT_LAST : QUO_LAST;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Advance the operand, remainder and result registers
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rad_q <= rad_i;
      div_q <= divisor_i;
      rem_q <= '0;
      res_q <= '0;
    end else if (busy_q) begin
      rad_q <= rad_sh;
      rem_q <= rem_nx;
      res_q <= {res_q[RES_W-2:0], ge};
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign result_o   = res_q;

endmodule

`default_nettype wire

>>> rtl/relative_l2_change_norm.sv
// Each squared term passes through the MAG, MUL and ACC states on the shared multiplier.
// An item stalls the input for two terms in single mode and four in spin mode, and a new
// item is taken only once the sequencer is back in idle. A last item then runs, per channel,
// two norms (NMUL_LO, NMUL_HI, NSUM, ROOT), a check, a division (skipped when the new norm
// is within epsilon) and a select, then loads the output register once it is free.
// Roots and division share one unit. Reset: configuration to reset values, sums clear.
`default_nettype none

module relative_l2_change_norm import rlcn_pkg::*; #(
  parameter int SAMPLE_BITS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  // input items
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [31:0]       old_alpha_i,
  input  logic [31:0]       new_alpha_i,
  input  logic [31:0]       old_beta_i,
  input  logic [31:0]       new_beta_i,
  input  logic              last_point_i,
  // result items
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [31:0]       change_norm_o,
  output logic              absolute_used_o,
  output logic              saturated_o
);

  rlcn_state_e state_q, state_d;

  logic [31:0] vol_q, eps_q;
  logic        spin_mode_q;

  logic signed [SAMPLE_BITS-1:0] samp_q [4];
  logic        spin_q, last_q;
  logic [1:0]  sel_q, sel_d;

  logic [31:0]      mag_q, mag_d;
  logic [31:0]      mul_a, mul_b;
  logic [ACC_W-1:0] prod_q, plo_q, hsum;
  logic [ACC_W-1:0] acc_q [4];
  logic [ACC_W:0]   acc_sum;
  logic             ovf_q;

  logic [ROOT_W-1:0] dn_q, nn_q;
  logic [RES_W-1:0]  r_q;
  logic              abs_q;
  logic [31:0]       best_q, chan_val;
  logic              best_abs_q, sat_q, chan_sat;

  logic        accept, out_load, cfg_wr;
  logic        out_valid_q, out_abs_q, out_sat_q;
  logic [31:0] out_norm_q;

  rlcn_req_t         unit_req;
  rlcn_sts_t         unit_sts;
  logic [RAD_W-1:0]  unit_rad;
  logic [RES_W-1:0]  unit_res;

  logic signed [SAMPLE_BITS-1:0] o_s, n_s;
  logic signed [32:0] o_x, n_x, d_x, t_x;
  logic [32:0]        t_abs;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vol_q       <= 32'h0100_0000;
      eps_q       <= 32'd1;
      spin_mode_q <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_VOLUME:  vol_q       <= pwdata;
        REG_EPSILON: eps_q       <= pwdata;
        REG_SPIN:    spin_mode_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_VOLUME:  prdata = vol_q;
      REG_EPSILON: prdata = eps_q;
      REG_SPIN:    prdata = {31'd0, spin_mode_q};
      default:     prdata = '0;
    endcase
  end

  // Magnitude of the selected term: difference on even steps, new sample on odd
  always_comb begin
    o_s   = sel_q[1] ? samp_q[2] : samp_q[0];
    n_s   = sel_q[1] ? samp_q[3] : samp_q[1];
    o_x   = 33'(o_s);
    n_x   = 33'(n_s);
    d_x   = n_x - o_x;
    t_x   = sel_q[0] ? n_x : d_x;
    t_abs = t_x[32] ? unsigned'(-t_x) : unsigned'(t_x);
    mag_d = t_abs[31:0];
  end

  // Shared multiplier operands
  always_comb begin
    case (state_q)
      ST_NMUL_LO: begin
        mul_a = acc_q[sel_q][31:0];
        mul_b = vol_q;
      end
      ST_NMUL_HI: begin
        mul_a = acc_q[sel_q][63:32];
        mul_b = vol_q;
      end
      default: begin
        mul_a = mag_q;
        mul_b = mag_q;
      end
    endcase
  end

  assign acc_sum  = {1'b0, acc_q[sel_q]} + {1'b0, prod_q};
  assign hsum     = prod_q + {32'd0, plo_q[63:32]};
  assign chan_sat = |r_q[RES_W-1:32];
  assign chan_val = chan_sat ? '1 : r_q[31:0];

  assign accept   = in_valid_i & ~in_stall_o;
  assign out_load = (state_q == ST_DONE) & (~out_valid_q | ~out_stall_i);

  // Sequencer: next state, step index and unit requests
  always_comb begin
    state_d      = state_q;
    sel_d        = sel_q;
    unit_req     = '{start: 1'b0, op: OP_SQRT};
    unit_rad     = {hsum, plo_q[31:24]};
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          sel_d   = 2'd0;
          state_d = ST_MAG;
        end
      end
      ST_MAG: state_d = ST_MUL;
      ST_MUL: state_d = ST_ACC;
      ST_ACC: begin
        if ((sel_q == 2'd3) || ((sel_q == 2'd1) && !spin_q)) begin
          sel_d   = 2'd0;
          state_d = last_q ? ST_NMUL_LO : ST_IDLE;
        end else begin
          sel_d   = sel_q + 2'd1;
          state_d = ST_MAG;
        end
      end
      ST_NMUL_LO: state_d = ST_NMUL_HI;
      ST_NMUL_HI: state_d = ST_NSUM;
      ST_NSUM: begin
        unit_req = '{start: 1'b1, op: OP_SQRT};
        state_d  = ST_ROOT;
      end
      ST_ROOT: begin
        if (unit_sts.done) begin
          if (!sel_q[0]) begin
            sel_d   = sel_q + 2'd1;
            state_d = ST_NMUL_LO;
          end else begin
            state_d = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        unit_rad = {dn_q, {(RAD_W-ROOT_W){1'b0}}};
        if (nn_q <= {{(ROOT_W-32){1'b0}}, eps_q}) begin
          state_d = ST_CHAN;
        end else begin
          unit_req = '{start: 1'b1, op: OP_DIV};
          state_d  = ST_DIV;
        end
      end
      ST_DIV: begin
        if (unit_sts.done) state_d = ST_CHAN;
      end
      ST_CHAN: begin
        if (!sel_q[1] && spin_q) begin
          sel_d   = sel_q + 2'd1;
          state_d = ST_NMUL_LO;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

  // State and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      sel_q   <= 2'd0;
      ovf_q   <= 1'b0;
      sat_q   <= 1'b0;
      for (int i = 0; i < 4; i++) acc_q[i] <= '0;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
      // accumulate with saturation
      if (state_q == ST_ACC) begin
        if (acc_sum[ACC_W]) begin
          acc_q[sel_q] <= '1;
          ovf_q        <= 1'b1;
        end else begin
          acc_q[sel_q] <= acc_sum[ACC_W-1:0];
        end
      end
      if (state_q == ST_CHAN) sat_q <= sat_q | chan_sat;
      // drop the vector state once the result is out
      if (out_load) begin
        for (int i = 0; i < 4; i++) acc_q[i] <= '0;
        ovf_q <= 1'b0;
        sat_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    prod_q <= {32'd0, mul_a} * {32'd0, mul_b};
    if (accept) begin
      samp_q[0] <= old_alpha_i[SAMPLE_BITS-1:0];
      samp_q[1] <= new_alpha_i[SAMPLE_BITS-1:0];
      samp_q[2] <= old_beta_i[SAMPLE_BITS-1:0];
      samp_q[3] <= new_beta_i[SAMPLE_BITS-1:0];
      spin_q    <= spin_mode_q;
      last_q    <= last_point_i;
    end
    if (state_q == ST_MAG) mag_q <= mag_d;
    if (state_q == ST_NMUL_HI) plo_q <= prod_q;
    if ((state_q == ST_ROOT) && unit_sts.done) begin
      if (!sel_q[0]) dn_q <= unit_res[ROOT_W-1:0];
      else           nn_q <= unit_res[ROOT_W-1:0];
    end
    if ((state_q == ST_CHECK) && (state_d == ST_CHAN)) begin
      r_q   <= {{(RES_W-ROOT_W){1'b0}}, dn_q};
      abs_q <= 1'b1;
    end
    if ((state_q == ST_DIV) && unit_sts.done) begin
      r_q   <= unit_res;
      abs_q <= 1'b0;
    end
    // keep alpha, replace only on a strictly larger beta result
    if ((state_q == ST_CHAN) && (!sel_q[1] || (chan_val > best_q))) begin
      best_q     <= chan_val;
      best_abs_q <= abs_q;
    end
    if (out_load) begin
      out_norm_q <= best_q;
      out_abs_q  <= best_abs_q;
      out_sat_q  <= sat_q | ovf_q;
    end
  end

  // Output register: hold the result item until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign change_norm_o   = out_norm_q;
  assign absolute_used_o = out_abs_q;
  assign saturated_o     = out_sat_q;

  // Shared square root and divide unit
  rlcn_shift_sub u_shift_sub (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (unit_req),
    .rad_i     (unit_rad),
    .divisor_i (nn_q),
    .sts_o     (unit_sts),
    .result_o  (unit_res)
  );

  // Checks
`include "relative_l2_change_norm_assert.svh"

  `RLCN_ASSERT_IMP(a_done_in_wait, clk_i, rst_ni, unit_sts.done, (state_q == ST_ROOT) || (state_q == ST_DIV))
  `RLCN_ASSERT_NXT(a_clear_after_out, clk_i, rst_ni, out_load, (acc_q[0] == '0) && (acc_q[3] == '0) && !ovf_q)
  `RLCN_ASSERT_NXT(a_accept_starts, clk_i, rst_ni, accept, (state_q == ST_MAG) && (sel_q == 2'd0))

endmodule

`default_nettype wire
